// ===== rtl/core/cpd_pkg.sv =====
// Package: shared command codes, decode enumerations and result struct for the control packet decoder.
`default_nettype none
package cpd_pkg;

  // Field widths
  localparam int unsigned PacketW  = 64;
  localparam int unsigned CmdW     = 6;
  localparam int unsigned KindW    = 4;
  localparam int unsigned ClassW   = 3;
  localparam int unsigned ChanW    = 2;
  localparam int unsigned SizeW    = 5;
  localparam int unsigned AddrW    = 40;
  localparam int unsigned WinW     = 32;
  localparam int unsigned UnitW    = 5;
  localparam int unsigned SeqW     = 4;
  localparam int unsigned TagW     = 5;
  localparam int unsigned FlagsW   = 6;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 32;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_RANGE_LOW  = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_RANGE_HIGH = 8'd1;

  // Fixed command encodings
  localparam logic [CmdW-1:0] CMD_NOP      = 6'h00;
  localparam logic [CmdW-1:0] CMD_SYNC     = 6'h3F;
  localparam logic [CmdW-1:0] CMD_RDRESP   = 6'h30;
  localparam logic [CmdW-1:0] CMD_TGTDONE  = 6'h33;
  localparam logic [CmdW-1:0] CMD_BCAST    = 6'h3A;
  localparam logic [CmdW-1:0] CMD_FENCE    = 6'h3C;
  localparam logic [CmdW-1:0] CMD_ATOMIC   = 6'h3D;
  localparam logic [CmdW-1:0] CMD_EXTFLOW  = 6'h37;
  localparam logic [CmdW-1:0] CMD_ADDREXT  = 6'h3E;
  localparam logic [CmdW-1:0] CMD_FLUSH    = 6'h02;
  // Command field prefixes
  localparam logic [1:0]      PFX_WRITE    = 2'b01;  // bits 4:3
  localparam logic [1:0]      PFX_READ     = 2'b01;  // bits 5:4
  localparam logic [2:0]      PFX_POSTWR   = 3'b101; // bits 5:3
  localparam logic [2:0]      PFX_NPWR     = 3'b001; // bits 5:3

  // Command kinds
  localparam logic [KindW-1:0] K_NOP     = 4'd0;
  localparam logic [KindW-1:0] K_SYNC    = 4'd1;
  localparam logic [KindW-1:0] K_RDRESP  = 4'd2;
  localparam logic [KindW-1:0] K_TGTDONE = 4'd3;
  localparam logic [KindW-1:0] K_BCAST   = 4'd4;
  localparam logic [KindW-1:0] K_FENCE   = 4'd5;
  localparam logic [KindW-1:0] K_ATOMIC  = 4'd6;
  localparam logic [KindW-1:0] K_EXTFLOW = 4'd7;
  localparam logic [KindW-1:0] K_ADDREXT = 4'd8;
  localparam logic [KindW-1:0] K_FLUSH   = 4'd9;
  localparam logic [KindW-1:0] K_WRITE   = 4'd10;
  localparam logic [KindW-1:0] K_READ    = 4'd11;
  localparam logic [KindW-1:0] K_RSVD    = 4'd12;

  // Packet classes
  localparam logic [ClassW-1:0] CL_INFO   = 3'd0;
  localparam logic [ClassW-1:0] CL_RESP   = 3'd1;
  localparam logic [ClassW-1:0] CL_REQ    = 3'd2;
  localparam logic [ClassW-1:0] CL_ADDREXT = 3'd3;
  localparam logic [ClassW-1:0] CL_RSVD   = 3'd4;

  // Virtual channels
  localparam logic [ChanW-1:0] CH_POSTED  = 2'd0;
  localparam logic [ChanW-1:0] CH_NPOSTED = 2'd1;
  localparam logic [ChanW-1:0] CH_RESP    = 2'd2;
  localparam logic [ChanW-1:0] CH_NONE    = 2'd3;

  // Window bounds handed from the register file to the decoder
  typedef struct packed {
    logic [WinW-1:0] range_low;
    logic [WinW-1:0] range_high;
  } cpd_window_t;

  // One decoded result
  typedef struct packed {
    logic [KindW-1:0]  command_kind;
    logic [ClassW-1:0] packet_class;
    logic [ChanW-1:0]  channel;
    logic              is_short;
    logic              has_data;
    logic [SizeW-1:0]  size_m1;
    logic [AddrW-1:0]  address;
    logic              in_window;
    logic [UnitW-1:0]  unit_id;
    logic [SeqW-1:0]   sequence_id;
    logic [TagW-1:0]   source_tag;
    logic [FlagsW-1:0] flags;
  } cpd_result_t;

endpackage
`default_nettype wire

// ===== rtl/core/cpd_cfg_regs.sv =====
// Configuration register file holding the address window bounds.
`default_nettype none
module cpd_cfg_regs
  import cpd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_valid,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data,
  output cpd_window_t              window
);

  logic [WinW-1:0] range_low_r, range_low_nxt;
  logic [WinW-1:0] range_high_r, range_high_nxt;

  // Decode the write; drop writes to unknown indexes
  always_comb begin
    range_low_nxt  = range_low_r;
    range_high_nxt = range_high_r;
    if (cfg_valid) begin
      if (cfg_index == CFG_RANGE_LOW) begin
        range_low_nxt = cfg_data;
      end else if (cfg_index == CFG_RANGE_HIGH) begin
        range_high_nxt = cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_low_r  <= '0;
      range_high_r <= '0;
    end else begin
      range_low_r  <= range_low_nxt;
      range_high_r <= range_high_nxt;
    end
  end

  assign window.range_low  = range_low_r;
  assign window.range_high = range_high_r;

endmodule
`default_nettype wire

// ===== rtl/core/cpd_decode.sv =====
// Combinational decode of one registered control packet into a result struct.
`default_nettype none
module cpd_decode
  import cpd_pkg::*;
(
  input  wire logic [PacketW-1:0] packet,
  input  wire cpd_window_t        window,
  output cpd_result_t             result
);

  logic [CmdW-1:0]  cmd;
  logic [KindW-1:0] kind;
  logic [ClassW-1:0] pclass;
  logic [ChanW-1:0] chan;
  logic             short_pkt;
  logic             data_pkt;
  logic [3:0]       len_m1;
  logic [SizeW-1:0] size;
  logic [AddrW-1:0] addr;
  logic [WinW-1:0]  addr_hi;
  logic             win;
  logic             chain;
  logic             data_err;

  assign cmd = packet[CmdW-1:0];

  // Command kind: exact codes first, then the write and read prefixes
  always_comb begin
    priority if (cmd == CMD_NOP)        kind = K_NOP;
    else if (cmd == CMD_SYNC)           kind = K_SYNC;
    else if (cmd == CMD_RDRESP)         kind = K_RDRESP;
    else if (cmd == CMD_TGTDONE)        kind = K_TGTDONE;
    else if (cmd == CMD_BCAST)          kind = K_BCAST;
    else if (cmd == CMD_FENCE)          kind = K_FENCE;
    else if (cmd == CMD_ATOMIC)         kind = K_ATOMIC;
    else if (cmd == CMD_EXTFLOW)        kind = K_EXTFLOW;
    else if (cmd == CMD_ADDREXT)        kind = K_ADDREXT;
    else if (cmd == CMD_FLUSH)          kind = K_FLUSH;
    else if (cmd[4:3] == PFX_WRITE)     kind = K_WRITE;
    else if (cmd[5:4] == PFX_READ)      kind = K_READ;
    else                                kind = K_RSVD;
  end

  // Packet class straight from the command
  always_comb begin
    priority if (cmd == CMD_NOP || cmd == CMD_SYNC || cmd == CMD_EXTFLOW) begin
      pclass = CL_INFO;
    end else if (cmd == CMD_RDRESP || cmd == CMD_TGTDONE) begin
      pclass = CL_RESP;
    end else if (cmd[5:3] == PFX_NPWR || cmd[5:3] == PFX_POSTWR ||
                 cmd[5:4] == PFX_READ || cmd == CMD_BCAST || cmd == CMD_FENCE ||
                 cmd == CMD_ATOMIC || cmd == CMD_FLUSH) begin
      pclass = CL_REQ;
    end else if (cmd == CMD_ADDREXT) begin
      pclass = CL_ADDREXT;
    end else begin
      pclass = CL_RSVD;
    end
  end

  // Virtual channel and length from the kind
  always_comb begin
    unique case (kind)
      K_WRITE:                    chan = packet[5] ? CH_POSTED : CH_NPOSTED;
      K_ATOMIC, K_FLUSH, K_READ:  chan = CH_NPOSTED;
      K_FENCE, K_BCAST:           chan = CH_POSTED;
      K_RDRESP, K_TGTDONE:        chan = CH_RESP;
      default:                    chan = CH_NONE;
    endcase
  end

  always_comb begin
    unique case (kind)
      K_WRITE, K_READ, K_BCAST, K_ATOMIC, K_RSVD: short_pkt = 1'b0;
      K_EXTFLOW:                                  short_pkt = ~packet[6];
      default:                                    short_pkt = 1'b1;
    endcase
  end

  assign data_pkt = (kind == K_WRITE) || (kind == K_RDRESP) || (kind == K_ATOMIC);

  // Data length; byte reads carry one doubleword
  assign len_m1 = (!packet[5] && packet[4] && !packet[2]) ? 4'd0 : packet[25:22];

  always_comb begin
    priority if (short_pkt && data_pkt) size = {1'b0, len_m1} + 5'd1;
    else if (short_pkt)                 size = 5'd0;
    else if (data_pkt)                  size = {1'b0, len_m1} + 5'd2;
    else                                size = 5'd1;
  end

  // Address with bit 2 cleared for atomics, then the window compare
  assign addr    = {packet[63:27], packet[26] & (kind != K_ATOMIC), 2'b00};
  assign addr_hi = addr[AddrW-1:8];
  assign win     = !short_pkt && (addr_hi >= window.range_low) &&
                   (addr_hi < window.range_high);

  // Flag bits
  assign chain    = (cmd[5:3] == PFX_POSTWR) && packet[19];
  assign data_err = packet[5] && packet[20];

  always_comb begin
    result.command_kind = kind;
    result.packet_class = pclass;
    result.channel      = chan;
    result.is_short     = short_pkt;
    result.has_data     = data_pkt;
    result.size_m1      = size;
    result.address      = addr;
    result.in_window    = win;
    result.unit_id      = packet[12:8];
    result.sequence_id  = {packet[7:6], packet[14:13]};
    result.source_tag   = packet[20:16];
    result.flags        = {packet[21], packet[29], data_err, packet[21], chain, packet[15]};
  end

endmodule
`default_nettype wire

// ===== rtl/core/control_packet_decoder_top.sv =====
// Top level of the control packet decoder: input register, decode, result register.
//
// Usage:
//   Input: drive in_packet and pulse start; the packet is taken at any clock
//   edge with start high and busy low. busy is always low, so a packet can
//   be taken on every cycle.
//   Output: each packet gives one result, shown on the out_ ports for one
//   cycle with out_strobe high. Results leave in the order packets arrived.
//   Pipeline: an accepted packet passes the input register, the decode logic
//   and then the result register, which drives the out_ ports.
//   Throughput: one packet per clock, set by the single decode stage.
//   Configuration: cfg_index 0 is the inclusive low bound and index 1 the
//   exclusive high bound of the window on address bits 39:8; cfg_ready is
//   always high, writes to other indexes are dropped. Write only while idle.
//   Reset: synchronous rst_n clears the pipeline valid bits and both window
//   bounds; no result is shown in the cycle after reset.
//   The receiver cannot stall: results are never held.
`default_nettype none
module control_packet_decoder_top
  import cpd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output      logic                busy,
  input  wire logic [PacketW-1:0]  in_packet,
  output      logic                out_strobe,
  output      logic [KindW-1:0]    out_command_kind,
  output      logic [ClassW-1:0]   out_packet_class,
  output      logic [ChanW-1:0]    out_channel,
  output      logic                out_is_short,
  output      logic                out_has_data,
  output      logic [SizeW-1:0]    out_size_m1,
  output      logic [AddrW-1:0]    out_address,
  output      logic                out_in_window,
  output      logic [UnitW-1:0]    out_unit_id,
  output      logic [SeqW-1:0]     out_sequence_id,
  output      logic [TagW-1:0]     out_source_tag,
  output      logic [FlagsW-1:0]   out_flags,
  input  wire logic                cfg_valid,
  output      logic                cfg_ready,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data
);

  cpd_window_t      window;
  cpd_result_t      dec_result;
  logic             in_valid_r;
  logic [PacketW-1:0] packet_r;
  logic             out_valid_r;
  cpd_result_t      result_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  cpd_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .window    (window)
  );

  cpd_decode u_decode (
    .packet (packet_r),
    .window (window),
    .result (dec_result)
  );

  // Capture the incoming transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      packet_r <= in_packet;
    end
  end

  // Register the decoded result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid_r) begin
      result_r <= dec_result;
    end
  end

  assign out_strobe       = out_valid_r;
  assign out_command_kind = result_r.command_kind;
  assign out_packet_class = result_r.packet_class;
  assign out_channel      = result_r.channel;
  assign out_is_short     = result_r.is_short;
  assign out_has_data     = result_r.has_data;
  assign out_size_m1      = result_r.size_m1;
  assign out_address      = result_r.address;
  assign out_in_window    = result_r.in_window;
  assign out_unit_id      = result_r.unit_id;
  assign out_sequence_id  = result_r.sequence_id;
  assign out_source_tag   = result_r.source_tag;
  assign out_flags        = result_r.flags;

endmodule
`default_nettype wire

// ===== rtl/core/cpd_checker.sv =====
// Port-level checker for the control packet decoder and its bind statement.
`default_nettype none
module cpd_checker
  import cpd_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               out_strobe,
  input wire logic               out_is_short,
  input wire logic               out_has_data,
  input wire logic [SizeW-1:0]   out_size_m1,
  input wire logic               out_in_window,
  input wire logic [KindW-1:0]   out_command_kind,
  input wire logic [ChanW-1:0]   out_channel
);

  // Every accepted transaction yields a result after the input and result registers
  a_accept_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_strobe)
    else $error("accepted transaction produced no result");

  // No result without an accepted transaction
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    (!(start && !busy)) |=> ##1 !out_strobe)
    else $error("result strobe without a transaction");

  // Short packets never hit the window
  a_short_no_window: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_is_short) |-> !out_in_window)
    else $error("window hit on a short packet");

  // Short packet without data is one doubleword
  a_short_size: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_is_short && !out_has_data) |-> (out_size_m1 == 5'd0))
    else $error("bad size for short packet without data");

  // Read responses travel on the response channel
  a_resp_channel: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_command_kind == K_RDRESP) |-> (out_channel == CH_RESP))
    else $error("read response on wrong channel");

endmodule

bind control_packet_decoder_top cpd_checker u_cpd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_strobe       (out_strobe),
  .out_is_short     (out_is_short),
  .out_has_data     (out_has_data),
  .out_size_m1      (out_size_m1),
  .out_in_window    (out_in_window),
  .out_command_kind (out_command_kind),
  .out_channel      (out_channel)
);
`default_nettype wire
